// ----- design/svfeq_pkg.sv -----
// Shared types, constants and saturation helpers for the cascaded
// state-variable shelving equalizer. No dependencies.

package svfeq_pkg;

   // Sizing of the filter.
   localparam int MAX_SECTIONS = 32;
   localparam int CHANNELS = 8;
   localparam int SAMPLE_BITS = 24;

   localparam int COEF_ENTRIES = MAX_SECTIONS * 4;
   localparam int DELAY_ENTRIES = CHANNELS * MAX_SECTIONS;
   localparam int SECT_BITS = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int COEF_ADDR_BITS = SECT_BITS + 2;
   localparam int DELAY_ADDR_BITS = (DELAY_ENTRIES > 1) ? $clog2(DELAY_ENTRIES) : 1;

   // Fixed field widths of the word formats.
   localparam int CHANNEL_BITS = 3;
   localparam int COEF_IDX_BITS = 7;
   localparam int COEF_BITS = 32;
   localparam int GAIN_BITS = 24;
   localparam int COUNT_BITS = 6;

   // Internal arithmetic widths.
   localparam int STATE_BITS = 40;
   localparam int SPLIT_BITS = 20;
   localparam int PROD_FULL_BITS = 72;
   localparam int PROD_BITS = 44;
   localparam int ACC_BITS = 46;
   localparam int Q_FRAC = 28;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] CSR_SECTION_COUNT = 2'd0;
   localparam logic [1:0] CSR_OVERALL_GAIN = 2'd1;
   localparam logic [1:0] CSR_BYPASS = 2'd2;
   localparam logic [COUNT_BITS-1:0] SECTION_COUNT_RESET = '0;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1048576);

   // Opcodes of the input word.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF = 1'b1;

   typedef enum logic [1:0] {
      COEF_C1 = 2'd0,
      COEF_C2 = 2'd1,
      COEF_D0 = 2'd2,
      COEF_D1 = 2'd3
   } coef_kind_type;

   typedef enum logic [1:0] {
      MUL_Z1,
      MUL_Y,
      MUL_X
   } mul_src_type;

   typedef struct packed {
      logic                            opcode;
      logic [CHANNEL_BITS-1:0]         channel;
      logic signed [SAMPLE_BITS-1:0]   sample_in;
      logic [COEF_IDX_BITS-1:0]        coef_index;
      logic signed [COEF_BITS-1:0]     coef_value;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0]         out_channel;
      logic signed [SAMPLE_BITS-1:0]   sample_out;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]           section_count;
      logic signed [GAIN_BITS-1:0]     overall_gain;
      logic                            bypass;
   } cfg_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic                            load;
      logic                            coef_wr;
      logic                            clr_wr;
      logic [DELAY_ADDR_BITS-1:0]      clr_addr;
      logic                            delay_rd;
      logic                            delay_wr;
      logic [SECT_BITS-1:0]            sec;
      coef_kind_type                   coef_sel;
      mul_src_type                     mul_src;
      logic                            mul_gain;
      logic                            y_load;
      logic                            z2_load;
      logic                            acc_load;
      logic                            x_load;
      logic                            res_load;
      logic                            rsp_load;
   } cmd_type;

   // Clamp a wide sum to the 40-bit state range.
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_BITS-1:0] v);
      logic [ACC_BITS-STATE_BITS:0] top;
      top = v[ACC_BITS-1:STATE_BITS-1];
      if (top == '0 || top == '1) begin
         return v[STATE_BITS-1:0];
      end
      return v[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                           : {1'b0, {(STATE_BITS-1){1'b1}}};
   endfunction

   // Clamp a rounded product to the sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [PROD_BITS-1:0] v);
      logic [PROD_BITS-SAMPLE_BITS:0] top;
      top = v[PROD_BITS-1:SAMPLE_BITS-1];
      if (top == '0 || top == '1) begin
         return v[SAMPLE_BITS-1:0];
      end
      return v[PROD_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                            : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   endfunction

endpackage

// ----- design/cascaded_svf_shelving_eq_unit.sv -----
// Top level of the cascaded state-variable shelving equalizer.
// Depends on svfeq_pkg, svfeq_csr, svfeq_ctrl and svfeq_dp.

// Multichannel fixed-point audio equalizer. Each sample word carries a channel
// tag and runs in series through the first section_count state-variable
// sections (capped at MAX_SECTIONS), each keeping two 40-bit states per
// channel, and is then scaled by overall_gain (Q4.20) and saturated to the
// sample width. A coefficient word (opcode 1) writes one Q4.28 coefficient and
// returns nothing; every coefficient a sample will use must have been written
// first. In bypass the sample comes back unchanged while the states still
// update. After reset the block zeroes all DELAY_ENTRIES entries (256 as
// built) of the delay memories and holds req_ready low during that pass;
// configuration writes are taken throughout. Configuration should be written
// only while the block is idle. A coefficient word leaves the input open. A
// sample word runs through each section in use in turn (a registered read of
// the coefficient table and the delay memory, then the new y, the products and
// the new x) and then through the gain stage before it is offered on the
// result port; the single shared 32 x 40 multiplier forms each section's four
// coefficient products one per cycle. Gain uses the same multiplier. The
// result sits in an output register, so a new word is taken while an earlier
// result waits for rsp_ready.

module cascaded_svf_shelving_eq_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  svfeq_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output svfeq_pkg::rsp_type                  rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [svfeq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [svfeq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [svfeq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready
);

   svfeq_pkg::cfg_type cfg;
   svfeq_pkg::cmd_type cmd;
   logic               rsp_free;

   // Register file: section count, gain and bypass.
   svfeq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The sequencer owns the input handshake and steps the datapath through
   // the clearing pass, the section schedule and the gain stage.
   svfeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_free  (rsp_free),
      .cmd       (cmd)
   );

   // The datapath holds the memories, the multiplier and the output register.
   svfeq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_free  (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/svfeq_csr.sv -----
// Configuration registers of the equalizer behind a simple APB-style port.
// Depends on svfeq_pkg.

module svfeq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [svfeq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [svfeq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [svfeq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready,
   output svfeq_pkg::cfg_type                  cfg
);

   svfeq_pkg::cfg_type cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = csr_paddr[svfeq_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.section_count <= svfeq_pkg::SECTION_COUNT_RESET;
         cfg_ff.overall_gain <= svfeq_pkg::GAIN_RESET;
         cfg_ff.bypass <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            svfeq_pkg::CSR_SECTION_COUNT: begin
               cfg_ff.section_count <= csr_pwdata[svfeq_pkg::COUNT_BITS-1:0];
            end
            svfeq_pkg::CSR_OVERALL_GAIN: begin
               cfg_ff.overall_gain <= csr_pwdata[svfeq_pkg::GAIN_BITS-1:0];
            end
            svfeq_pkg::CSR_BYPASS: begin
               cfg_ff.bypass <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         svfeq_pkg::CSR_SECTION_COUNT: begin
            csr_prdata = svfeq_pkg::CSR_DATA_BITS'(cfg_ff.section_count);
         end
         svfeq_pkg::CSR_OVERALL_GAIN: begin
            csr_prdata = svfeq_pkg::CSR_DATA_BITS'(unsigned'(cfg_ff.overall_gain));
         end
         svfeq_pkg::CSR_BYPASS: begin
            csr_prdata = svfeq_pkg::CSR_DATA_BITS'(cfg_ff.bypass);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

// ----- design/svfeq_ctrl.sv -----
// Sequencer of the equalizer: clearing pass, section schedule and output hand-off.
// Depends on svfeq_pkg; drives svfeq_dp through svfeq_pkg::cmd_type.

module svfeq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  svfeq_pkg::req_type    req_data,
   input  svfeq_pkg::cfg_type    cfg,
   input  logic                  rsp_free,
   output svfeq_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SECTION,
      ST_GAIN_MUL,
      ST_GAIN_ADD,
      ST_GAIN_SAT,
      ST_FINISH
   } state_type;

   // Steps within one section.
   localparam logic [2:0] PH_READ = 3'd0;
   localparam logic [2:0] PH_Y = 3'd1;
   localparam logic [2:0] PH_MUL_Y = 3'd2;
   localparam logic [2:0] PH_Z2 = 3'd3;
   localparam logic [2:0] PH_ACC = 3'd4;
   localparam logic [2:0] PH_OUT = 3'd5;

   localparam int NSEC_BITS = svfeq_pkg::SECT_BITS + 1;

   state_type                              state_ff;
   logic [2:0]                             phase_ff;
   logic [svfeq_pkg::SECT_BITS-1:0]        sec_ff;
   logic [NSEC_BITS-1:0]                   nsec_ff;
   logic [svfeq_pkg::DELAY_ADDR_BITS-1:0]  clr_ff;
   logic                                   wb_ff;

   logic                  accept;
   logic                  chan_ok;
   logic                  last_sec;
   logic [NSEC_BITS-1:0]  nsec_req;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign chan_ok = int'(req_data.channel) < svfeq_pkg::CHANNELS;
   assign last_sec = (NSEC_BITS'(sec_ff) + NSEC_BITS'(1)) == nsec_ff;
   assign nsec_req = (int'(cfg.section_count) > svfeq_pkg::MAX_SECTIONS)
                   ? NSEC_BITS'(svfeq_pkg::MAX_SECTIONS)
                   : NSEC_BITS'(cfg.section_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= PH_READ;
         sec_ff <= '0;
         nsec_ff <= '0;
         clr_ff <= '0;
         wb_ff <= 1'b0;
      end else begin
         wb_ff <= (state_ff == ST_SECTION) && (phase_ff == PH_OUT);
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == svfeq_pkg::DELAY_ADDR_BITS'(svfeq_pkg::DELAY_ENTRIES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && req_data.opcode == svfeq_pkg::OP_SAMPLE && chan_ok) begin
                  nsec_ff <= nsec_req;
                  sec_ff <= '0;
                  phase_ff <= PH_READ;
                  state_ff <= (nsec_req == '0) ? ST_GAIN_MUL : ST_SECTION;
               end
            end
            ST_SECTION: begin
               if (phase_ff == PH_OUT) begin
                  phase_ff <= PH_READ;
                  if (last_sec) begin
                     state_ff <= ST_GAIN_MUL;
                  end else begin
                     sec_ff <= sec_ff + 1'b1;
                  end
               end else begin
                  phase_ff <= phase_ff + 3'd1;
               end
            end
            ST_GAIN_MUL: begin
               state_ff <= ST_GAIN_ADD;
            end
            ST_GAIN_ADD: begin
               state_ff <= ST_GAIN_SAT;
            end
            ST_GAIN_SAT: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.load = accept && req_data.opcode == svfeq_pkg::OP_SAMPLE;
      cmd.coef_wr = accept && req_data.opcode == svfeq_pkg::OP_COEF
                 && int'(req_data.coef_index) < svfeq_pkg::COEF_ENTRIES;
      cmd.clr_wr = (state_ff == ST_CLEAR);
      cmd.clr_addr = clr_ff;
      cmd.sec = sec_ff;
      cmd.coef_sel = svfeq_pkg::COEF_C1;
      cmd.mul_src = svfeq_pkg::MUL_Z1;
      // The previous section's states are written back while the next one
      // starts reading, or while the gain product starts.
      cmd.delay_wr = wb_ff && (state_ff == ST_SECTION || state_ff == ST_GAIN_MUL);
      if (state_ff == ST_SECTION) begin
         case (phase_ff)
            PH_READ: begin
               cmd.delay_rd = 1'b1;
               cmd.coef_sel = svfeq_pkg::COEF_C2;
            end
            PH_Y: begin
               cmd.y_load = 1'b1;
               cmd.coef_sel = svfeq_pkg::COEF_D1;
               cmd.mul_src = svfeq_pkg::MUL_Z1;
            end
            PH_MUL_Y: begin
               cmd.coef_sel = svfeq_pkg::COEF_D0;
               cmd.mul_src = svfeq_pkg::MUL_Z1;
            end
            PH_Z2: begin
               cmd.z2_load = 1'b1;
               cmd.coef_sel = svfeq_pkg::COEF_C1;
               cmd.mul_src = svfeq_pkg::MUL_Y;
            end
            PH_ACC: begin
               cmd.acc_load = 1'b1;
               cmd.mul_src = svfeq_pkg::MUL_Y;
            end
            PH_OUT: begin
               cmd.x_load = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (state_ff == ST_GAIN_MUL) begin
         cmd.mul_src = svfeq_pkg::MUL_X;
         cmd.mul_gain = 1'b1;
      end
      cmd.res_load = (state_ff == ST_GAIN_SAT);
      cmd.rsp_load = (state_ff == ST_FINISH) && rsp_free;
   end

endmodule

// ----- design/svfeq_dp.sv -----
// Datapath of the equalizer: coefficient and delay memories, the shared
// split multiplier, section arithmetic and the output register. Depends on svfeq_pkg.

module svfeq_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  svfeq_pkg::cmd_type    cmd,
   input  svfeq_pkg::req_type    req_data,
   input  svfeq_pkg::cfg_type    cfg,
   output logic                  rsp_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output svfeq_pkg::rsp_type    rsp_data
);

   localparam int SB = svfeq_pkg::SAMPLE_BITS;
   localparam int STB = svfeq_pkg::STATE_BITS;
   localparam int CB = svfeq_pkg::COEF_BITS;
   localparam int HI_BITS = STB - svfeq_pkg::SPLIT_BITS;
   localparam int PP_HI_BITS = CB + HI_BITS;
   localparam int PP_LO_BITS = CB + svfeq_pkg::SPLIT_BITS + 1;
   localparam int PFB = svfeq_pkg::PROD_FULL_BITS;
   localparam int PB = svfeq_pkg::PROD_BITS;
   localparam int AB = svfeq_pkg::ACC_BITS;
   localparam int DAB = svfeq_pkg::DELAY_ADDR_BITS;
   localparam logic signed [PFB-1:0] ROUND_HALF = PFB'(1) <<< (svfeq_pkg::Q_FRAC - 1);

   logic signed [CB-1:0]   coef_mem [svfeq_pkg::COEF_ENTRIES];
   logic signed [STB-1:0]  delay_one_mem [svfeq_pkg::DELAY_ENTRIES];
   logic signed [STB-1:0]  delay_two_mem [svfeq_pkg::DELAY_ENTRIES];

   logic [svfeq_pkg::CHANNEL_BITS-1:0] ch_ff;
   logic signed [SB-1:0]       smp_ff;
   logic signed [STB-1:0]      x_ff;
   logic signed [CB-1:0]       coef_q_ff;
   logic signed [STB-1:0]      z1_q_ff;
   logic signed [STB-1:0]      z2_q_ff;
   logic [DAB-1:0]             wb_addr_ff;
   logic signed [STB-1:0]      y_ff;
   logic signed [PP_HI_BITS-1:0] pp_hi_ff;
   logic signed [PP_LO_BITS-1:0] pp_lo_ff;
   logic signed [PB-1:0]       prod_ff;
   logic signed [STB-1:0]      z2n_ff;
   logic signed [AB-2:0]       acc_ff;
   logic signed [SB-1:0]       res_ff;
   logic                       rsp_valid_ff;
   svfeq_pkg::rsp_type         rsp_ff;

   logic [DAB-1:0]                          rd_addr;
   logic [svfeq_pkg::COEF_ADDR_BITS-1:0]    coef_rd_addr;
   logic signed [CB-1:0]                    mul_a;
   logic signed [STB-1:0]                   mul_b;
   logic signed [HI_BITS-1:0]               mul_b_hi;
   logic signed [svfeq_pkg::SPLIT_BITS:0]   mul_b_lo;
   logic signed [PP_HI_BITS-1:0]            pp_hi_in;
   logic signed [PP_LO_BITS-1:0]            pp_lo_in;
   logic signed [PFB-1:0]                   full_sum;
   logic signed [PB-1:0]                    prod_in;
   logic signed [STB-1:0]                   y_in;
   logic signed [STB-1:0]                   z2n_in;
   logic signed [AB-2:0]                    acc_in;
   logic signed [STB-1:0]                   x_in;
   logic signed [STB-1:0]                   z1_wb;
   logic signed [SB-1:0]                    res_in;

   assign rd_addr = DAB'(int'(ch_ff) * svfeq_pkg::MAX_SECTIONS + int'(cmd.sec));
   assign coef_rd_addr = {cmd.sec, cmd.coef_sel};

   // Coefficient table: written by coefficient words, read once per cycle.
   always_ff @(posedge clock) begin
      if (cmd.coef_wr) begin
         coef_mem[svfeq_pkg::COEF_ADDR_BITS'(req_data.coef_index)] <= req_data.coef_value;
      end
      coef_q_ff <= coef_mem[coef_rd_addr];
   end

   // Delay state memories share one address; cleared after reset.
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         delay_one_mem[cmd.clr_addr] <= '0;
         delay_two_mem[cmd.clr_addr] <= '0;
      end else if (cmd.delay_wr) begin
         delay_one_mem[wb_addr_ff] <= z1_wb;
         delay_two_mem[wb_addr_ff] <= z2n_ff;
      end
      if (cmd.delay_rd) begin
         z1_q_ff <= delay_one_mem[rd_addr];
         z2_q_ff <= delay_two_mem[rd_addr];
         wb_addr_ff <= rd_addr;
      end
   end

   // Shared multiplier: round(a * b / 2^28), b split into two halves.
   always_comb begin
      mul_a = cmd.mul_gain ? {cfg.overall_gain, 8'd0} : coef_q_ff;
      case (cmd.mul_src)
         svfeq_pkg::MUL_Z1: mul_b = z1_q_ff;
         svfeq_pkg::MUL_Y:  mul_b = y_ff;
         svfeq_pkg::MUL_X:  mul_b = x_ff;
         default:           mul_b = z1_q_ff;
      endcase
      mul_b_hi = mul_b[STB-1:svfeq_pkg::SPLIT_BITS];
      mul_b_lo = $signed({1'b0, mul_b[svfeq_pkg::SPLIT_BITS-1:0]});
      pp_hi_in = PP_HI_BITS'(mul_a) * PP_HI_BITS'(mul_b_hi);
      pp_lo_in = PP_LO_BITS'(mul_a) * PP_LO_BITS'(mul_b_lo);
      full_sum = $signed({pp_hi_ff, {svfeq_pkg::SPLIT_BITS{1'b0}}})
               + PFB'(pp_lo_ff) + ROUND_HALF;
      prod_in = full_sum[PFB-1:svfeq_pkg::Q_FRAC];
   end

   // Section arithmetic.
   always_comb begin
      y_in = svfeq_pkg::sat_state(AB'(x_ff) - AB'(z1_q_ff) - AB'(z2_q_ff));
      z2n_in = svfeq_pkg::sat_state(AB'(z2_q_ff) + AB'(prod_ff));
      acc_in = (AB-1)'(z2_q_ff) + (AB-1)'(prod_ff);
      x_in = svfeq_pkg::sat_state(AB'(acc_ff) + AB'(prod_ff));
      z1_wb = svfeq_pkg::sat_state(AB'(z1_q_ff) + AB'(prod_ff));
      res_in = cfg.bypass ? smp_ff : svfeq_pkg::sat_sample(prod_ff);
   end

   always_ff @(posedge clock) begin
      pp_hi_ff <= pp_hi_in;
      pp_lo_ff <= pp_lo_in;
      prod_ff <= prod_in;
      if (cmd.load) begin
         ch_ff <= req_data.channel;
         smp_ff <= req_data.sample_in;
         x_ff <= STB'(req_data.sample_in);
      end else if (cmd.x_load) begin
         x_ff <= x_in;
      end
      if (cmd.y_load) begin
         y_ff <= y_in;
      end
      if (cmd.z2_load) begin
         z2n_ff <= z2n_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= acc_in;
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff.out_channel <= ch_ff;
         rsp_ff.sample_out <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ----- design/svfeq_checker.sv -----
// Port-level checks for the equalizer top level, attached by a bind.
// Depends on svfeq_pkg and cascaded_svf_shelving_eq_unit.

module svfeq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input svfeq_pkg::req_type                  req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input svfeq_pkg::rsp_type                  rsp_data,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [svfeq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [svfeq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [svfeq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   input logic                                csr_pready
);

   logic sample_acc;
   logic coef_acc;

   assign sample_acc = req_valid && req_ready && req_data.opcode == svfeq_pkg::OP_SAMPLE
                    && int'(req_data.channel) < svfeq_pkg::CHANNELS;
   assign coef_acc = req_valid && req_ready && req_data.opcode == svfeq_pkg::OP_COEF;

   // The clearing pass keeps the input closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // A sample word closes the input right after it is taken.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      sample_acc |=> !req_ready)
      else $error("input still open after a sample word");

   // A coefficient word leaves the input open.
   a_coef_quick: assert property (@(posedge clock) disable iff (reset)
      coef_acc |=> req_ready)
      else $error("input closed after a coefficient word");

   // A result never appears in the cycle right after a word was taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result offered too soon after an accepted word");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind cascaded_svf_shelving_eq_unit svfeq_checker u_svfeq_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for the cascaded state-variable shelving equalizer.
// Depends on svfeq_pkg and cascaded_svf_shelving_eq_unit; keeps its own
// fixed-point filter, state and register copies to predict every result word.
`timescale 1ns / 1ps

module tb;
   import svfeq_pkg::*;

   // Wide signed word for the prediction arithmetic: a 32 x 40 bit product
   // plus rounding fits with room to spare.
   typedef logic signed [79:0] wide_word;

   localparam wide_word HALF_COEF_LSB = 80'sd134217728;   // 2^27, Q4.28 rounding
   localparam wide_word HALF_GAIN_LSB = 80'sd524288;      // 2^19, Q4.20 rounding
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off for the pressure test
   localparam int SETTLE_CYCLES = 8;    // lets a trailing coefficient word settle
   localparam int END_CYCLES = 250;     // outlasts the slowest sample word
   localparam int PHASES = 20;
   localparam int PHASE_WORDS = 45;
   localparam int QUIET_PHASES = 3;
   localparam int PRINT_CAP = 60;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // Copies of the block's registers, coefficient table and per-channel
   // delay states, advanced as words are accepted.
   logic [COUNT_BITS-1:0] cfg_sections;
   logic signed [GAIN_BITS-1:0] cfg_gain;
   logic cfg_bypass;
   logic signed [COEF_BITS-1:0] coef_mirror [COEF_ENTRIES];
   logic signed [STATE_BITS-1:0] z1_mirror [DELAY_ENTRIES];
   logic signed [STATE_BITS-1:0] z2_mirror [DELAY_ENTRIES];

   // Result words still owed by the block, oldest first.
   rsp_type pending_out [$];

   int error_count = 0;
   bit quiet = 1'b0;          // set for the final stretch: no gaps, no stalls
   bit hold_request = 1'b0;   // asks the result side for one long hold-off
   int idle_pct = 20;         // chance that the sender pauses before a word
   int stall_pct = 20;        // chance that the receiver starts a stall burst

   cascaded_svf_shelving_eq_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Fixed-point filter prediction
   // ---------------------------------------------------------------------

   // Clamp to a signed range of the given width.
   function automatic wide_word clamp(input wide_word v, input int bits);
      wide_word hi;
      wide_word lo;
      hi = (wide_word'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Q4.28 coefficient times a state-scale value, rounded to the nearest
   // state LSB with ties going up. The arithmetic shift is a floor, so adding
   // half an LSB first gives exactly that rounding.
   function automatic wide_word coef_product(input logic signed [COEF_BITS-1:0] c,
                                             input wide_word v);
      wide_word cw;
      cw = c;
      return (cw * v + HALF_COEF_LSB) >>> Q_FRAC;
   endfunction

   function automatic int coef_slot(input int section, input coef_kind_type kind);
      return section * 4 + int'(kind);
   endfunction

   // Runs one sample of one channel through the active sections, updating
   // that channel's states, and returns the expected output sample. The
   // states advance even in bypass.
   function automatic logic signed [SAMPLE_BITS-1:0] equalize_sample(
      input logic [CHANNEL_BITS-1:0] ch, input logic signed [SAMPLE_BITS-1:0] xin);
      wide_word x;
      wide_word y;
      wide_word z1;
      wide_word z2;
      wide_word g;
      wide_word r;
      int n;
      int k;
      n = (int'(cfg_sections) > MAX_SECTIONS) ? MAX_SECTIONS : int'(cfg_sections);
      x = xin;
      for (int s = 0; s < n; s++) begin
         k = int'(ch) * MAX_SECTIONS + s;
         z1 = z1_mirror[k];
         z2 = z2_mirror[k];
         y = clamp(x - z1 - z2, STATE_BITS);
         x = clamp(coef_product(coef_mirror[coef_slot(s, COEF_D0)], y)
                   + coef_product(coef_mirror[coef_slot(s, COEF_D1)], z1) + z2,
                   STATE_BITS);
         z2_mirror[k] = clamp(z2 + coef_product(coef_mirror[coef_slot(s, COEF_C2)], z1),
                              STATE_BITS);
         z1_mirror[k] = clamp(z1 + coef_product(coef_mirror[coef_slot(s, COEF_C1)], y),
                              STATE_BITS);
      end
      if (cfg_bypass) begin
         return xin;
      end
      g = cfg_gain;
      r = clamp((x * g + HALF_GAIN_LSB) >>> 20, SAMPLE_BITS);
      return r[SAMPLE_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Word builders and value choices
   // ---------------------------------------------------------------------

   // The coefficient fields of a sample word are ignored, so they carry noise.
   function automatic req_type sample_word(input logic [CHANNEL_BITS-1:0] ch,
                                           input logic signed [SAMPLE_BITS-1:0] v);
      req_type w;
      w.opcode = OP_SAMPLE;
      w.channel = ch;
      w.sample_in = v;
      w.coef_index = COEF_IDX_BITS'($urandom);
      w.coef_value = $urandom;
      return w;
   endfunction

   function automatic req_type coef_word(input logic [COEF_IDX_BITS-1:0] idx,
                                         input logic signed [COEF_BITS-1:0] v);
      req_type w;
      w.opcode = OP_COEF;
      w.channel = CHANNEL_BITS'($urandom);
      w.sample_in = SAMPLE_BITS'($urandom);
      w.coef_index = idx;
      w.coef_value = v;
      return w;
   endfunction

   // Mostly moderate program material, sometimes anything at all.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      if ($urandom_range(0, 99) < 80) begin
         return SAMPLE_BITS'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      end
      return SAMPLE_BITS'($urandom);
   endfunction

   // Integrator gains between 0 and 0.5 keep a section well behaved and the
   // mix gains lie within +-2; a few words take any value to drive the
   // states into saturation.
   function automatic logic signed [COEF_BITS-1:0] pick_coef(input coef_kind_type kind);
      if ($urandom_range(0, 99) < 5) begin
         return $urandom;
      end
      if (kind == COEF_C1 || kind == COEF_C2) begin
         return $urandom_range(0, 1 << 27);
      end
      return int'($urandom_range(0, 1 << 30)) - (1 << 29);
   endfunction

   // ---------------------------------------------------------------------
   // Shared driving and checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) begin
         $display("tb: mismatch at %0t: %s", $realtime, what);
      end
      error_count++;
   endtask

   // Offers one word, holding it until accepted, and advances the prediction
   // on the accepting edge. Valid stays high afterwards until the next
   // falling edge, where either the next word or a gap replaces it.
   task automatic send_word(input req_type w);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 13);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      if (w.opcode == OP_COEF) begin
         coef_mirror[w.coef_index] = w.coef_value;
      end else begin
         pending_out.push_back('{out_channel: w.channel,
                                 sample_out: equalize_sample(w.channel, w.sample_in)});
      end
   endtask

   // Stops offering words and waits until every owed result has come back,
   // plus SETTLE_CYCLES for a trailing coefficient word.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, always done on an idle block: setup cycle, then access
   // cycle; the register takes the value on the edge that ends the access.
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_BITS-1:0] value);
      drain_results();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         CSR_SECTION_COUNT: cfg_sections = value[COUNT_BITS-1:0];
         CSR_OVERALL_GAIN: cfg_gain = value[GAIN_BITS-1:0];
         CSR_BYPASS: cfg_bypass = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Every accepted result word is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out.size() == 0) begin
            report_mismatch($sformatf("result word ch %0d sample %0d with none pending",
                                      rsp_data.out_channel, rsp_data.sample_out));
         end else begin
            if (rsp_data.out_channel !== pending_out[0].out_channel) begin
               report_mismatch($sformatf("out_channel got %0d want %0d",
                                         rsp_data.out_channel, pending_out[0].out_channel));
            end
            if (rsp_data.sample_out !== pending_out[0].sample_out) begin
               report_mismatch($sformatf("ch %0d sample_out got %0d want %0d",
                                         pending_out[0].out_channel, rsp_data.sample_out,
                                         pending_out[0].sample_out));
            end
            void'(pending_out.pop_front());
         end
      end
   end

   // Result side: ready by default, random stall bursts, and on request one
   // long hold-off counted here so that the sender keeps pushing words into a
   // block that cannot hand its results on.
   initial begin : result_side
      int burst;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            burst = $urandom_range(1, 13);
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // With no sections in use the output is the input times the gain: check
   // unity, the sample extremes, and saturation at both gain extremes.
   task automatic test_zero_sections();
      send_word(sample_word(0, 0));
      send_word(sample_word(7, 24'sh7FFFFF));
      send_word(sample_word(3, 24'sh800000));
      send_word(sample_word(5, -24'sd1));
      send_word(sample_word(1, 24'sd1));
      csr_write(CSR_OVERALL_GAIN, 32'sd8388607);
      send_word(sample_word(0, 24'sh7FFFFF));
      send_word(sample_word(7, 24'sh800000));
      csr_write(CSR_OVERALL_GAIN, -32'sd8388608);
      send_word(sample_word(6, 24'sh800000));
      csr_write(CSR_OVERALL_GAIN, 32'sd0);
      send_word(sample_word(2, 24'sd12345));
      csr_write(CSR_OVERALL_GAIN, 32'sd1048576);
   endtask

   // Loads the first two sections, with coefficient extremes in the first,
   // runs two of them on the edge channels, then checks that bypass returns
   // the input while the states keep moving underneath.
   task automatic test_first_sections();
      send_word(coef_word(coef_slot(0, COEF_C1), 32'sh7FFFFFFF));
      send_word(coef_word(coef_slot(0, COEF_C2), 32'sh80000000));
      send_word(coef_word(coef_slot(0, COEF_D0), 32'sd268435456));
      send_word(coef_word(coef_slot(0, COEF_D1), 32'sd0));
      send_word(coef_word(coef_slot(1, COEF_C1), 32'sd67108864));
      send_word(coef_word(coef_slot(1, COEF_C2), 32'sd33554432));
      send_word(coef_word(coef_slot(1, COEF_D0), -32'sd268435456));
      send_word(coef_word(coef_slot(1, COEF_D1), 32'sd268435456));
      csr_write(CSR_SECTION_COUNT, 32'd2);
      send_word(sample_word(0, 24'sh7FFFFF));
      send_word(sample_word(7, 24'sh800000));
      send_word(sample_word(0, 24'sh7FFFFF));
      send_word(sample_word(7, 24'sd0));
      send_word(sample_word(4, 24'sh123456));
      csr_write(CSR_BYPASS, 32'd1);
      send_word(sample_word(0, 24'sh800000));
      send_word(sample_word(7, 24'sh7FFFFF));
      csr_write(CSR_BYPASS, 32'd0);
      send_word(sample_word(0, 24'sd100));
   endtask

   // The receiver holds off for a long stretch while samples keep coming, so
   // the output register fills and the block has to stall its input.
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) begin
         send_word(sample_word(CHANNEL_BITS'($urandom), pick_sample()));
      end
      drain_results();
   endtask

   // Writes the whole table, after which any section count is legal, then
   // checks that counts above the maximum behave as the maximum.
   task automatic test_full_table();
      for (int i = 0; i < COEF_ENTRIES; i++) begin
         send_word(coef_word(i, pick_coef(coef_kind_type'(i % 4))));
      end
      csr_write(CSR_SECTION_COUNT, 32'd63);
      send_word(sample_word(0, pick_sample()));
      send_word(sample_word(7, pick_sample()));
      csr_write(CSR_SECTION_COUNT, 32'd33);
      send_word(sample_word(3, pick_sample()));
      csr_write(CSR_SECTION_COUNT, 32'd32);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         send_word(sample_word(ch, pick_sample()));
      end
   endtask

   // Random phases: each picks a register setting, a sender idle rate and a
   // receiver stall rate, then streams mostly samples on random channels with
   // some coefficient rewrites mixed in. The first phases pin the extremes;
   // the last ones run without any gaps or stalls.
   task automatic test_random_traffic();
      int sections;
      int gain;
      int r;
      for (int p = 0; p < PHASES; p++) begin
         r = $urandom_range(0, 9);
         if (p == 0) sections = MAX_SECTIONS;
         else if (p == 1) sections = 63;
         else if (p == 2) sections = 0;
         else if (r < 6) sections = $urandom_range(1, 6);
         else if (r < 8) sections = $urandom_range(7, 20);
         else if (r == 8) sections = $urandom_range(21, MAX_SECTIONS);
         else sections = $urandom_range(MAX_SECTIONS + 1, 63);

         if (p == 3) gain = 8388607;
         else if (p == 4) gain = -8388608;
         else if ($urandom_range(0, 99) < 70) begin
            gain = $urandom_range(1 << 18, 1 << 22);
            if ($urandom_range(0, 1) == 1) gain = -gain;
         end else begin
            gain = int'($urandom << 8) >>> 8;
         end

         csr_write(CSR_SECTION_COUNT, sections);
         csr_write(CSR_OVERALL_GAIN, gain);
         csr_write(CSR_BYPASS, ($urandom_range(0, 99) < 15) ? 32'd1 : 32'd0);

         quiet = (p >= PHASES - QUIET_PHASES);
         case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 10;
            2: idle_pct = 25;
            default: idle_pct = 50;
         endcase
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 25;
            default: stall_pct = 50;
         endcase

         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ($urandom_range(0, 99) < 15) begin
               r = $urandom_range(0, COEF_ENTRIES - 1);
               send_word(coef_word(r, pick_coef(coef_kind_type'(r % 4))));
            end else begin
               send_word(sample_word(CHANNEL_BITS'($urandom_range(0, CHANNELS - 1)),
                                     pick_sample()));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      // The delay states start cleared; the table is only read after it has
      // been written, so its starting contents never matter.
      cfg_sections = SECTION_COUNT_RESET;
      cfg_gain = GAIN_RESET;
      cfg_bypass = 1'b0;
      for (int i = 0; i < COEF_ENTRIES; i++) coef_mirror[i] = '0;
      for (int i = 0; i < DELAY_ENTRIES; i++) begin
         z1_mirror[i] = '0;
         z2_mirror[i] = '0;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its delay memories after reset with req_ready low;
      // the first words simply wait for that pass to end.
      test_zero_sections();
      test_first_sections();
      test_backpressure();
      test_full_table();
      test_random_traffic();

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest legal run.
   initial begin
      #15000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
